// ===== hdl/stereo_peak_rms_clip_meter_core_defines.svh =====
// Assertion macros shared by the level meter checker.
// No dependencies; the including file supplies signals named clock and reset.
`ifndef STEREO_PEAK_RMS_CLIP_METER_CORE_DEFINES_SVH
`define STEREO_PEAK_RMS_CLIP_METER_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is high
`define SPRCM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high
`define SPRCM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Check what follows a reset cycle
`define SPRCM_ASSERT_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/sprcm_pkg.sv =====
// Shared types and constants for the stereo peak / RMS / clip level meter.
// No dependencies.
`timescale 1ns / 1ps

package sprcm_pkg;

   // Result field widths and limits
   localparam int LEVEL_W  = 24;
   localparam int CLIP_W   = 14;
   localparam int CLIP_MAX = 16383;

   // Square sum accumulator and root datapath
   localparam int SUM_W  = 64;
   localparam int ROOT_W = 32;

   // Divide and root sequencing
   localparam int STEP_W = 6;
   localparam logic [STEP_W-1:0] DIV_LAST  = 6'd63;
   localparam logic [STEP_W-1:0] ROOT_LAST = 6'd31;

   // Decoupling queue between front and back
   localparam int QUE_DEPTH  = 4;
   localparam int QUE_PTR_W  = 2;
   localparam int QUE_FILL_W = 3;

   // Control register map
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_ENABLE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_ENABLE = 2'd1;

   // Per-pair classification passed from front to back
   typedef struct packed {
      logic en_left;
      logic en_right;
      logic clip_left;
      logic clip_right;
      logic last;
   } sprcm_flags_type;

endpackage

// ===== hdl/stereo_peak_rms_clip_meter_core.sv =====
// Top level of the stereo peak / RMS / clip level meter.
// Uses sprcm_pkg, sprcm_front, sprcm_queue and sprcm_back.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  sample_left, sample_right, last_in_block
//   rsp      out        rsp_valid/rsp_ready  peak_level, rms_level, clip_total
//   csr      in         csr_valid/csr_ready  csr_index, csr_data (always ready)
//
// Sample pairs are taken one per cycle while nothing stalls; the front pipeline
// has three stages and a four-entry queue feeds the back end, which accumulates
// one pair per cycle while ready. A pair marked last holds the back end for 64
// divide steps and 32 square root steps, then hand-off; empty blocks skip both.
// Reset is synchronous and clears all control state; there is no clearing pass.
// Either side may stall at any time; a pending result waits in the output register.
`timescale 1ns / 1ps

module stereo_peak_rms_clip_meter_core #(
   parameter int MAX_BLOCK   = 4096,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [SAMPLE_BITS-1:0]     req_sample_left,
   input  logic signed [SAMPLE_BITS-1:0]     req_sample_right,
   input  logic                              req_last_in_block,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sprcm_pkg::LEVEL_W-1:0]     rsp_peak_level,
   output logic [sprcm_pkg::LEVEL_W-1:0]     rsp_rms_level,
   output logic [sprcm_pkg::CLIP_W-1:0]      rsp_clip_total,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sprcm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic                              csr_data
);
   import sprcm_pkg::*;

   localparam int SQ_W    = 2 * SAMPLE_BITS;
   localparam int ENTRY_W = $bits(sprcm_flags_type) + 3 * SAMPLE_BITS + 3 * SQ_W + 1;

   logic                   left_enable_ff, left_enable_in;
   logic                   right_enable_ff, right_enable_in;

   logic                   fr_valid, fr_ready;
   sprcm_flags_type        fr_flags;
   logic [SAMPLE_BITS-1:0] fr_mag_left, fr_mag_right, fr_mag_max;
   logic [SQ_W-1:0]        fr_sq_left, fr_sq_right;
   logic [SQ_W:0]          fr_sq_both;

   logic                   bk_valid, bk_ready;
   sprcm_flags_type        bk_flags;
   logic [SAMPLE_BITS-1:0] bk_mag_left, bk_mag_right, bk_mag_max;
   logic [SQ_W-1:0]        bk_sq_left, bk_sq_right;
   logic [SQ_W:0]          bk_sq_both;

   logic [ENTRY_W-1:0]     que_in_data, que_out_data;

   // Control registers
   assign csr_ready = 1'b1;

   always_comb begin
      left_enable_in  = left_enable_ff;
      right_enable_in = right_enable_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LEFT_ENABLE:  left_enable_in  = csr_data;
            CSR_RIGHT_ENABLE: right_enable_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_enable_ff  <= 1'b1;
         right_enable_ff <= 1'b1;
      end else begin
         left_enable_ff  <= left_enable_in;
         right_enable_ff <= right_enable_in;
      end
   end

   sprcm_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .en_left         (left_enable_ff),
      .en_right        (right_enable_ff),
      .in_valid        (req_valid),
      .in_ready        (req_ready),
      .in_sample_left  (req_sample_left),
      .in_sample_right (req_sample_right),
      .in_last         (req_last_in_block),
      .out_valid       (fr_valid),
      .out_ready       (fr_ready),
      .out_flags       (fr_flags),
      .out_mag_left    (fr_mag_left),
      .out_mag_right   (fr_mag_right),
      .out_mag_max     (fr_mag_max),
      .out_sq_left     (fr_sq_left),
      .out_sq_right    (fr_sq_right),
      .out_sq_both     (fr_sq_both)
   );

   // Pack and unpack queue entries
   assign que_in_data = {fr_flags, fr_mag_left, fr_mag_right, fr_mag_max,
                         fr_sq_left, fr_sq_right, fr_sq_both};
   assign {bk_flags, bk_mag_left, bk_mag_right, bk_mag_max,
           bk_sq_left, bk_sq_right, bk_sq_both} = que_out_data;

   sprcm_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   (que_in_data),
      .out_valid (bk_valid),
      .out_ready (bk_ready),
      .out_data  (que_out_data)
   );

   sprcm_back #(
      .MAX_BLOCK   (MAX_BLOCK),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (bk_valid),
      .in_ready       (bk_ready),
      .in_flags       (bk_flags),
      .in_mag_left    (bk_mag_left),
      .in_mag_right   (bk_mag_right),
      .in_mag_max     (bk_mag_max),
      .in_sq_left     (bk_sq_left),
      .in_sq_right    (bk_sq_right),
      .in_sq_both     (bk_sq_both),
      .out_valid      (rsp_valid),
      .out_ready      (rsp_ready),
      .out_peak_level (rsp_peak_level),
      .out_rms_level  (rsp_rms_level),
      .out_clip_total (rsp_clip_total)
   );

endmodule

// ===== hdl/sprcm_front.sv =====
// Front end of the level meter: accepts sample pairs, forms magnitudes,
// clip flags, squares and the pair sum over a three-stage pipeline. Uses sprcm_pkg.
`timescale 1ns / 1ps

module sprcm_front #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en_left,
   input  logic                              en_right,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic signed [SAMPLE_BITS-1:0]     in_sample_left,
   input  logic signed [SAMPLE_BITS-1:0]     in_sample_right,
   input  logic                              in_last,
   output logic                              out_valid,
   input  logic                              out_ready,
   output sprcm_pkg::sprcm_flags_type        out_flags,
   output logic [SAMPLE_BITS-1:0]            out_mag_left,
   output logic [SAMPLE_BITS-1:0]            out_mag_right,
   output logic [SAMPLE_BITS-1:0]            out_mag_max,
   output logic [2*SAMPLE_BITS-1:0]          out_sq_left,
   output logic [2*SAMPLE_BITS-1:0]          out_sq_right,
   output logic [2*SAMPLE_BITS:0]            out_sq_both
);
   import sprcm_pkg::*;

   localparam logic [SAMPLE_BITS-1:0] UNITY = SAMPLE_BITS'(1) << (SAMPLE_BITS - 4);

   logic                       advance;
   logic [SAMPLE_BITS-1:0]     raw_left;
   logic [SAMPLE_BITS-1:0]     raw_right;

   logic                       a_valid_ff, a_valid_in;
   sprcm_flags_type            a_flags_ff, a_flags_in;
   logic [SAMPLE_BITS-1:0]     a_mag_left_ff, a_mag_left_in;
   logic [SAMPLE_BITS-1:0]     a_mag_right_ff, a_mag_right_in;

   logic                       b_valid_ff;
   sprcm_flags_type            b_flags_ff;
   logic [SAMPLE_BITS-1:0]     b_mag_left_ff, b_mag_right_ff;
   logic [SAMPLE_BITS-1:0]     b_mag_max_ff, b_mag_max_in;
   logic [2*SAMPLE_BITS-1:0]   b_sq_left_ff, b_sq_left_in;
   logic [2*SAMPLE_BITS-1:0]   b_sq_right_ff, b_sq_right_in;

   logic                       c_valid_ff;
   sprcm_flags_type            c_flags_ff;
   logic [SAMPLE_BITS-1:0]     c_mag_left_ff, c_mag_right_ff, c_mag_max_ff;
   logic [2*SAMPLE_BITS-1:0]   c_sq_left_ff, c_sq_right_ff;
   logic [2*SAMPLE_BITS:0]     c_sq_both_ff, c_sq_both_in;

   // Move the whole pipeline when the last stage is empty or drains
   assign advance  = !c_valid_ff || out_ready;
   assign in_ready = advance;

   // Stage A: magnitudes and clip classification
   always_comb begin
      raw_left          = in_sample_left;
      raw_right         = in_sample_right;
      a_valid_in        = in_valid;
      a_mag_left_in     = raw_left[SAMPLE_BITS-1] ? (~raw_left + SAMPLE_BITS'(1)) : raw_left;
      a_mag_right_in    = raw_right[SAMPLE_BITS-1] ? (~raw_right + SAMPLE_BITS'(1)) : raw_right;
      a_flags_in.en_left    = en_left;
      a_flags_in.en_right   = en_right;
      a_flags_in.clip_left  = a_mag_left_in > UNITY;
      a_flags_in.clip_right = a_mag_right_in > UNITY;
      a_flags_in.last       = in_last;
   end

   // Stage B: squares and larger magnitude
   always_comb begin
      b_sq_left_in  = a_mag_left_ff * a_mag_left_ff;
      b_sq_right_in = a_mag_right_ff * a_mag_right_ff;
      b_mag_max_in  = (a_mag_left_ff > a_mag_right_ff) ? a_mag_left_ff : a_mag_right_ff;
   end

   // Stage C: sum of both squares
   assign c_sq_both_in = {1'b0, b_sq_left_ff} + {1'b0, b_sq_right_ff};

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         a_flags_ff     <= a_flags_in;
         a_mag_left_ff  <= a_mag_left_in;
         a_mag_right_ff <= a_mag_right_in;

         b_flags_ff     <= a_flags_ff;
         b_mag_left_ff  <= a_mag_left_ff;
         b_mag_right_ff <= a_mag_right_ff;
         b_mag_max_ff   <= b_mag_max_in;
         b_sq_left_ff   <= b_sq_left_in;
         b_sq_right_ff  <= b_sq_right_in;

         c_flags_ff     <= b_flags_ff;
         c_mag_left_ff  <= b_mag_left_ff;
         c_mag_right_ff <= b_mag_right_ff;
         c_mag_max_ff   <= b_mag_max_ff;
         c_sq_left_ff   <= b_sq_left_ff;
         c_sq_right_ff  <= b_sq_right_ff;
         c_sq_both_ff   <= c_sq_both_in;
      end
   end

   assign out_valid     = c_valid_ff;
   assign out_flags     = c_flags_ff;
   assign out_mag_left  = c_mag_left_ff;
   assign out_mag_right = c_mag_right_ff;
   assign out_mag_max   = c_mag_max_ff;
   assign out_sq_left   = c_sq_left_ff;
   assign out_sq_right  = c_sq_right_ff;
   assign out_sq_both   = c_sq_both_ff;

endmodule

// ===== hdl/sprcm_queue.sv =====
// Short first-in first-out queue between the front and back of the level meter.
// Uses sprcm_pkg for its depth.
`timescale 1ns / 1ps

module sprcm_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   import sprcm_pkg::*;

   logic [WIDTH-1:0]      mem_ff [QUE_DEPTH];
   logic [QUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUE_FILL_W-1:0] fill_ff, fill_in;
   logic                  push;
   logic                  pop;

   assign in_ready  = fill_ff != QUE_FILL_W'(QUE_DEPTH);
   assign out_valid = fill_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUE_PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + QUE_FILL_W'(push) - QUE_FILL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the incoming entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== hdl/sprcm_back.sv =====
// Back end of the level meter: accumulates peak, square sum and counts per block,
// then runs a bit-serial divide and square root and holds the result. Uses sprcm_pkg.
`timescale 1ns / 1ps

module sprcm_back #(
   parameter int MAX_BLOCK   = 4096,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  sprcm_pkg::sprcm_flags_type        in_flags,
   input  logic [SAMPLE_BITS-1:0]            in_mag_left,
   input  logic [SAMPLE_BITS-1:0]            in_mag_right,
   input  logic [SAMPLE_BITS-1:0]            in_mag_max,
   input  logic [2*SAMPLE_BITS-1:0]          in_sq_left,
   input  logic [2*SAMPLE_BITS-1:0]          in_sq_right,
   input  logic [2*SAMPLE_BITS:0]            in_sq_both,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [sprcm_pkg::LEVEL_W-1:0]     out_peak_level,
   output logic [sprcm_pkg::LEVEL_W-1:0]     out_rms_level,
   output logic [sprcm_pkg::CLIP_W-1:0]      out_clip_total
);
   import sprcm_pkg::*;

   localparam int CNT_W = $clog2(2 * MAX_BLOCK + 1);
   localparam int SQ_W  = 2 * SAMPLE_BITS + 1;
   localparam logic [CNT_W-1:0]  COUNT_CAP = CNT_W'(2 * MAX_BLOCK);
   localparam logic [ROOT_W:0]   RMS_CAP   = (ROOT_W + 1)'(1) << (SAMPLE_BITS - 1);

   localparam logic [1:0] ST_ACCUM = 2'd0;
   localparam logic [1:0] ST_DIV   = 2'd1;
   localparam logic [1:0] ST_ROOT  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [SAMPLE_BITS-1:0]  peak_ff, peak_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        clip_ff, clip_in;
   logic [LEVEL_W-1:0]      peak_res_ff, peak_res_in;
   logic [CLIP_W-1:0]       clip_res_ff, clip_res_in;
   logic [SUM_W-1:0]        quo_ff, quo_in;
   logic [CNT_W-1:0]        div_ff, div_in;
   logic [CNT_W-1:0]        rem_ff, rem_in;
   logic [ROOT_W-1:0]       rrem_ff, rrem_in;
   logic [ROOT_W-1:0]       root_ff, root_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    out_load;
   logic [LEVEL_W-1:0]      out_peak_ff;
   logic [LEVEL_W-1:0]      out_rms_ff;
   logic [CLIP_W-1:0]       out_clip_ff;

   // Accumulate path
   logic                    take_left, take_right;
   logic [CNT_W-1:0]        count_mid, count_acc, clip_acc;
   logic [SQ_W-1:0]         add_sel;
   logic [SAMPLE_BITS-1:0]  peak_cand, peak_acc;
   logic [SUM_W:0]          sum_wide;
   logic [SUM_W-1:0]        sum_acc;
   logic [CNT_W+CLIP_W-1:0] clip_ext;
   logic [CLIP_W-1:0]       clip_sat;

   // Divide and root steps
   logic [CNT_W:0]          div_shift, div_diff;
   logic                    div_ge;
   logic [ROOT_W+1:0]       root_shift, root_trial, root_diff;
   logic                    root_ge;
   logic [ROOT_W:0]         root_ext, rms_clamp;

   assign in_ready = state_ff == ST_ACCUM;

   // Decide which samples of the pair still fit under the count cap
   always_comb begin
      take_left  = in_flags.en_left && (count_ff < COUNT_CAP);
      count_mid  = count_ff + CNT_W'(take_left);
      take_right = in_flags.en_right && (count_mid < COUNT_CAP);
      count_acc  = count_mid + CNT_W'(take_right);
      clip_acc   = clip_ff + CNT_W'(take_left & in_flags.clip_left)
                           + CNT_W'(take_right & in_flags.clip_right);
      unique case ({take_left, take_right})
         2'b11: begin
            add_sel   = in_sq_both;
            peak_cand = in_mag_max;
         end
         2'b10: begin
            add_sel   = {1'b0, in_sq_left};
            peak_cand = in_mag_left;
         end
         2'b01: begin
            add_sel   = {1'b0, in_sq_right};
            peak_cand = in_mag_right;
         end
         default: begin
            add_sel   = '0;
            peak_cand = '0;
         end
      endcase
      // Saturating square sum
      sum_wide = (SUM_W + 1)'(sum_ff) + (SUM_W + 1)'(add_sel);
      sum_acc  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      peak_acc = (peak_cand > peak_ff) ? peak_cand : peak_ff;
      clip_ext = (CNT_W + CLIP_W)'(clip_acc);
      clip_sat = (clip_ext > (CNT_W + CLIP_W)'(CLIP_MAX)) ? CLIP_W'(CLIP_MAX)
                                                          : CLIP_W'(clip_acc);
   end

   // One restoring divide step and one root step
   always_comb begin
      div_shift  = {rem_ff, quo_ff[SUM_W-1]};
      div_ge     = div_shift >= {1'b0, div_ff};
      div_diff   = div_shift - {1'b0, div_ff};
      root_shift = {rrem_ff, quo_ff[SUM_W-1:SUM_W-2]};
      root_trial = {root_ff, 2'b01};
      root_ge    = root_shift >= root_trial;
      root_diff  = root_shift - root_trial;
      root_ext   = {1'b0, root_ff};
      rms_clamp  = (root_ext > RMS_CAP) ? RMS_CAP : root_ext;
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      peak_in      = peak_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      clip_in      = clip_ff;
      peak_res_in  = peak_res_ff;
      clip_res_in  = clip_res_ff;
      quo_in       = quo_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      rrem_in      = rrem_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      out_load     = 1'b0;
      out_valid_in = out_valid_ff && !out_ready;
      unique case (state_ff)
         ST_ACCUM: begin
            if (in_valid) begin
               if (in_flags.last) begin
                  // Close the block: latch results, clear totals, start the divide unless nothing was counted
                  peak_res_in = LEVEL_W'(peak_acc);
                  clip_res_in = clip_sat;
                  quo_in      = sum_acc;
                  div_in      = count_acc;
                  rem_in      = '0;
                  rrem_in     = '0;
                  root_in     = '0;
                  step_in     = '0;
                  peak_in     = '0;
                  sum_in      = '0;
                  count_in    = '0;
                  clip_in     = '0;
                  state_in    = (count_acc == '0) ? ST_DONE : ST_DIV;
               end else begin
                  peak_in  = peak_acc;
                  sum_in   = sum_acc;
                  count_in = count_acc;
                  clip_in  = clip_acc;
               end
            end
         end
         ST_DIV: begin
            quo_in  = {quo_ff[SUM_W-2:0], div_ge};
            rem_in  = div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
            step_in = step_ff + STEP_W'(1);
            if (step_ff == DIV_LAST) begin
               step_in  = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            quo_in  = {quo_ff[SUM_W-3:0], 2'b00};
            rrem_in = root_ge ? root_diff[ROOT_W-1:0] : root_shift[ROOT_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], root_ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == ROOT_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hand off once the output register is free
            if (!out_valid_ff || out_ready) begin
               out_load     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   // Control and block totals
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         peak_ff      <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         clip_ff      <= '0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         peak_ff      <= peak_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         clip_ff      <= clip_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      peak_res_ff <= peak_res_in;
      clip_res_ff <= clip_res_in;
      quo_ff      <= quo_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      rrem_ff     <= rrem_in;
      root_ff     <= root_in;
      if (out_load) begin
         out_peak_ff <= peak_res_ff;
         out_rms_ff  <= LEVEL_W'(rms_clamp);
         out_clip_ff <= clip_res_ff;
      end
   end

   assign out_valid      = out_valid_ff;
   assign out_peak_level = out_peak_ff;
   assign out_rms_level  = out_rms_ff;
   assign out_clip_total = out_clip_ff;

endmodule

// ===== hdl/sprcm_checker.sv =====
// Port-level checks for the level meter, bound to the top level.
// Depends on stereo_peak_rms_clip_meter_core_defines.svh and sprcm_pkg.
`timescale 1ns / 1ps
`include "stereo_peak_rms_clip_meter_core_defines.svh"

module sprcm_checker #(
   parameter int MAX_BLOCK   = 4096,
   parameter int SAMPLE_BITS = 24
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [sprcm_pkg::LEVEL_W-1:0] rsp_peak_level,
   input logic [sprcm_pkg::LEVEL_W-1:0] rsp_rms_level,
   input logic [sprcm_pkg::CLIP_W-1:0]  rsp_clip_total
);
   import sprcm_pkg::*;

   localparam logic NARROW = SAMPLE_BITS <= LEVEL_W;

   // No result straight out of reset
   `SPRCM_ASSERT_RESET(a_no_rsp_after_reset, !rsp_valid, "result valid after reset")

   // A stalled result holds
   `SPRCM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_peak_level) && $stable(rsp_rms_level) && $stable(rsp_clip_total), "stalled result changed")

   // The mean level never exceeds the peak
   `SPRCM_ASSERT_NOW(a_rms_below_peak, NARROW && rsp_valid, rsp_rms_level <= rsp_peak_level, "rms above peak")

   // A silent block reports no clipping and no level
   `SPRCM_ASSERT_NOW(a_silent_block, NARROW && rsp_valid && rsp_peak_level == '0, rsp_clip_total == '0 && rsp_rms_level == '0, "silent block with level")

   // Clip count stays within the block's sample cap
   `SPRCM_ASSERT_NOW(a_clip_bound, rsp_valid, 32'(rsp_clip_total) <= 32'(2 * MAX_BLOCK), "clip count beyond block cap")

endmodule

bind stereo_peak_rms_clip_meter_core sprcm_checker #(
   .MAX_BLOCK   (MAX_BLOCK),
   .SAMPLE_BITS (SAMPLE_BITS)
) u_sprcm_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the stereo peak / RMS / clip level meter core.
// Depends on sprcm_pkg and stereo_peak_rms_clip_meter_core; predicts every block
// result in SystemVerilog and scores each response transaction against it.
`timescale 1ns / 1ps

module testbench;

   localparam int SAMPLE_W = 24;
   localparam int LVL_W    = sprcm_pkg::LEVEL_W;
   localparam int CLP_W    = sprcm_pkg::CLIP_W;

   localparam int UNITY      = 1 << 20;
   localparam int FULL_SCALE = 1 << 23;
   localparam int MAX_POS    = 8388607;
   localparam int MIN_NEG    = -8388608;
   localparam int COUNT_CAP  = 2 * 4096;

   localparam logic [sprcm_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   localparam int SETTLE_CYCLES  = 150;
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int PRINT_LIMIT    = 100;
   localparam int PRESSURE_HOLD  = 600;
   localparam int PHASE_ITEMS    = 100;

   typedef struct {
      logic [LVL_W-1:0] peak;
      logic [LVL_W-1:0] rms;
      logic [CLP_W-1:0] clip;
   } level_result_type;

   logic clock = 1'b0;
   logic reset;

   logic                       req_valid;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_left;
   logic signed [SAMPLE_W-1:0] req_sample_right;
   logic                       req_last_in_block;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [LVL_W-1:0]           rsp_peak_level;
   logic [LVL_W-1:0]           rsp_rms_level;
   logic [CLP_W-1:0]           rsp_clip_total;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [sprcm_pkg::CSR_IDX_W-1:0] csr_index;
   logic                       csr_data;

   // Predicted meter state
   logic              meter_left_en  = 1'b1;
   logic              meter_right_en = 1'b1;
   longint unsigned   meter_peak       = 0;
   longint unsigned   meter_square_sum = 0;
   longint unsigned   meter_count      = 0;
   longint unsigned   meter_clips      = 0;

   level_result_type expected_levels[$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  hold_request   = 0;
   bit  req_quiet      = 1'b0;
   bit  rsp_quiet      = 1'b0;

   stereo_peak_rms_clip_meter_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_left   (req_sample_left),
      .req_sample_right  (req_sample_right),
      .req_last_in_block (req_last_in_block),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_peak_level    (rsp_peak_level),
      .rsp_rms_level     (rsp_rms_level),
      .rsp_clip_total    (rsp_clip_total),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // Largest r with r*r <= x, built one bit at a time from the top
   function automatic longint unsigned floor_sqrt(input longint unsigned x);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= x)
            root = trial;
      end
      return root;
   endfunction

   // Fold one enabled channel sample into the running block statistics
   function automatic void fold_sample(input logic signed [SAMPLE_W-1:0] s);
      longint unsigned mag;
      longint unsigned sq;
      if (meter_count >= COUNT_CAP)
         return;
      mag = (s < 0) ? longint'(-longint'(s)) : longint'(s);
      if (mag > meter_peak)
         meter_peak = mag;
      sq = mag * mag;
      if (meter_square_sum > ~64'd0 - sq)
         meter_square_sum = ~64'd0;
      else
         meter_square_sum += sq;
      if (mag > UNITY)
         meter_clips++;
      meter_count++;
   endfunction

   // Update the statistics for one pair; on the last pair queue the block levels
   function automatic void accumulate_pair(input logic signed [SAMPLE_W-1:0] l,
                                           input logic signed [SAMPLE_W-1:0] r,
                                           input logic last);
      level_result_type res;
      longint unsigned  mean_sq;
      longint unsigned  root;
      if (meter_left_en)
         fold_sample(l);
      if (meter_right_en)
         fold_sample(r);
      if (!last)
         return;
      mean_sq = (meter_count != 0) ? meter_square_sum / meter_count : 0;
      root = floor_sqrt(mean_sq);
      if (root > FULL_SCALE)
         root = FULL_SCALE;
      res.peak = LVL_W'(meter_peak);
      res.rms  = LVL_W'(root);
      res.clip = (meter_clips > 16383) ? CLP_W'(16383) : CLP_W'(meter_clips);
      expected_levels.insert(expected_levels.size(), res);
      meter_peak       = 0;
      meter_square_sum = 0;
      meter_count      = 0;
      meter_clips      = 0;
   endfunction

   // Mix of full-range noise and values at the interesting edges
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_W'(MAX_POS);
         1: return SAMPLE_W'(MIN_NEG);
         2: return SAMPLE_W'(UNITY + int'($urandom_range(0, 2)) - 1);
         3: return SAMPLE_W'(-UNITY - int'($urandom_range(0, 2)) + 1);
         4: return SAMPLE_W'(int'($urandom_range(0, 255)) - 128);
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   // Offer one pair after a random gap and hold it until the transaction
   task automatic send_pair(input logic signed [SAMPLE_W-1:0] l,
                            input logic signed [SAMPLE_W-1:0] r,
                            input logic last);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_sample_left   <= l;
      req_sample_right  <= r;
      req_last_in_block <= last;
      do @(negedge clock); while (!req_ready);
      accumulate_pair(l, r, last);
      @(posedge clock);
   endtask

   // Write one register; keep valid up when another write follows directly
   task automatic write_csr(input logic [sprcm_pkg::CSR_IDX_W-1:0] idx,
                            input logic data, input bit keep_valid);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(negedge clock); while (!csr_ready);
      case (idx)
         sprcm_pkg::CSR_LEFT_ENABLE:  meter_left_en  = data;
         sprcm_pkg::CSR_RIGHT_ENABLE: meter_right_en = data;
         default: ;
      endcase
      @(posedge clock);
      if (!keep_valid)
         csr_valid <= 1'b0;
   endtask

   task automatic write_enables(input logic l_en, input logic r_en);
      write_csr(sprcm_pkg::CSR_LEFT_ENABLE, l_en, 1'b1);
      write_csr(sprcm_pkg::CSR_RIGHT_ENABLE, r_en, 1'b0);
   endtask

   // Wait for every pending result, then let the pipeline settle
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_random_block(input int len);
      for (int i = 0; i < len; i++)
         send_pair(pick_sample(), pick_sample(), i == len - 1);
   endtask

   // Full-scale values, unity boundary and a silent block
   task automatic test_extremes();
      send_pair(SAMPLE_W'(MAX_POS), SAMPLE_W'(MIN_NEG), 1'b0);
      send_pair(SAMPLE_W'(UNITY), SAMPLE_W'(-UNITY), 1'b0);
      send_pair(SAMPLE_W'(UNITY + 1), SAMPLE_W'(-UNITY - 1), 1'b0);
      send_pair(SAMPLE_W'(0), SAMPLE_W'(-1), 1'b0);
      send_pair(SAMPLE_W'(1), SAMPLE_W'(0), 1'b1);
      send_pair(SAMPLE_W'(MIN_NEG), SAMPLE_W'(MIN_NEG), 1'b1);
      send_pair(SAMPLE_W'(0), SAMPLE_W'(0), 1'b1);
   endtask

   // One channel, the other, none; an unmapped index must change nothing
   task automatic test_channel_enables();
      drain_pipeline();
      write_csr(CSR_UNMAPPED, 1'b0, 1'b1);
      write_enables(1'b1, 1'b0);
      send_pair(SAMPLE_W'(UNITY + 5), SAMPLE_W'(MAX_POS), 1'b0);
      send_pair(SAMPLE_W'(-3), SAMPLE_W'(MIN_NEG), 1'b1);
      drain_pipeline();
      write_enables(1'b0, 1'b1);
      send_pair(SAMPLE_W'(MAX_POS), SAMPLE_W'(-UNITY - 7), 1'b0);
      send_pair(SAMPLE_W'(MIN_NEG), SAMPLE_W'(12345), 1'b1);
      drain_pipeline();
      write_enables(1'b0, 1'b0);
      send_pair(SAMPLE_W'(MAX_POS), SAMPLE_W'(MIN_NEG), 1'b0);
      send_pair(SAMPLE_W'(UNITY + 1), SAMPLE_W'(-UNITY - 1), 1'b1);
      drain_pipeline();
      write_enables(1'b1, 1'b1);
   endtask

   // Change the enables between two halves of one block
   task automatic test_enable_mid_block();
      send_pair(SAMPLE_W'(UNITY * 2), SAMPLE_W'(-UNITY * 3), 1'b0);
      send_pair(SAMPLE_W'(-77), SAMPLE_W'(UNITY), 1'b0);
      drain_pipeline();
      write_enables(1'b0, 1'b1);
      send_pair(SAMPLE_W'(MAX_POS), SAMPLE_W'(UNITY + 9), 1'b0);
      send_pair(SAMPLE_W'(MIN_NEG), SAMPLE_W'(-1000), 1'b1);
      drain_pipeline();
      write_enables(1'b1, 1'b1);
   endtask

   // Long block back to back: mixed levels, then a full-scale clipping run
   task automatic test_long_block();
      int total;
      logic signed [SAMPLE_W-1:0] l;
      logic signed [SAMPLE_W-1:0] r;
      total = 300;
      req_quiet = 1'b1;
      for (int i = 0; i < total; i++) begin
         if (i < total / 2) begin
            l = SAMPLE_W'(int'($urandom_range(0, 4 * UNITY)) - 2 * UNITY);
            r = SAMPLE_W'(int'($urandom_range(0, 4 * UNITY)) - 2 * UNITY);
         end else begin
            l = SAMPLE_W'(MAX_POS);
            r = SAMPLE_W'(MIN_NEG);
         end
         send_pair(l, r, i == total - 1);
      end
      req_quiet = 1'b0;
      drain_pipeline();
   endtask

   // Hold off the result side while pairs keep coming so the input stalls
   task automatic test_backpressure();
      req_quiet    = 1'b1;
      hold_request = PRESSURE_HOLD;
      for (int n = 0; n < 24; n++)
         send_random_block($urandom_range(1, 3));
      req_quiet = 1'b0;
      drain_pipeline();
   endtask

   // Random blocks over several enable settings, one phase without idling
   task automatic test_random_traffic();
      int items;
      int len;
      logic [1:0] enables;
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: enables = 2'b11;
            1: enables = 2'b10;
            2: enables = 2'b01;
            3: enables = 2'b00;
            default: enables = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 3)) : 2'b11;
         endcase
         drain_pipeline();
         write_enables(enables[1], enables[0]);
         req_quiet = (phase == 4);
         rsp_quiet = (phase == 4);
         items = 0;
         while (items < PHASE_ITEMS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
            send_random_block(len);
            items += len;
         end
      end
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
      drain_pipeline();
   endtask

   // Result side: random stall per transaction, plus a long hold on request
   initial begin : rsp_side
      int stall;
      int hold;
      rsp_ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_request > 0) begin
            hold         = hold_request;
            hold_request = 0;
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         stall = rsp_quiet ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(negedge clock); while (!rsp_valid && hold_request == 0);
         @(posedge clock);
      end
   end

   // Score each response transaction against the oldest expected levels
   always @(negedge clock) begin : level_check
      level_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_levels.size() == 0) begin
            report_mismatch("result with none pending", 0, 0);
         end else begin
            want = expected_levels.pop_front();
            if (rsp_peak_level !== want.peak)
               report_mismatch("peak_level", rsp_peak_level, want.peak);
            if (rsp_rms_level !== want.rms)
               report_mismatch("rms_level", rsp_rms_level, want.rms);
            if (rsp_clip_total !== want.clip)
               report_mismatch("clip_total", rsp_clip_total, want.clip);
         end
      end
   end

   initial begin : test_sequence
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_sample_left   <= '0;
      req_sample_right  <= '0;
      req_last_in_block <= 1'b0;
      csr_valid         <= 1'b0;
      csr_index         <= sprcm_pkg::CSR_LEFT_ENABLE;
      csr_data          <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_extremes();
      test_channel_enables();
      test_enable_mid_block();
      test_long_block();
      test_backpressure();
      test_random_traffic();

      drain_pipeline();
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
